@@ rtl/core/ils_pkg.sv @@
// Shared types, codes and sizing helpers for the indexed list store.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 9;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 9;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 48;

  localparam int CAPACITY_DEF = 256;
  localparam int CAPACITY_MAX = 4096;
  localparam int CTRL_POS_W   = $clog2(CAPACITY_MAX + 1);

  localparam int TREE_RADIX   = 16;
  localparam int TREE_SHIFT   = 4;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic                  rd;
    logic [CTRL_POS_W-1:0] pos;
    logic [DATA_W-1:0]     value;
  } ils_ctrl_t;

  function automatic int level_nodes(input int n, input int lvl);
    int m;
    m = n;
    for (int i = 0; i < lvl; i++) begin
      m = (m + TREE_RADIX - 1) >> TREE_SHIFT;
    end
    return m;
  endfunction

  function automatic int tree_levels(input int n);
    int m;
    int lv;
    m  = n;
    lv = 0;
    while (m > 1) begin
      m  = (m + TREE_RADIX - 1) >> TREE_SHIFT;
      lv = lv + 1;
    end
    return (lv < 1) ? 1 : lv;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ils_cell.sv @@
// One storage cell of the entry chain: holds one entry, shifts with its neighbours.
// Depends on ils_pkg.
`default_nettype none

module ils_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire ils_pkg::ils_ctrl_t        ctrl,
  input  wire logic [ils_pkg::DATA_W-1:0] left,
  input  wire logic [ils_pkg::DATA_W-1:0] right,
  output logic      [ils_pkg::DATA_W-1:0] entry,
  output logic      [ils_pkg::DATA_W-1:0] hit
);
  import ils_pkg::*;

  localparam logic [CTRL_POS_W-1:0] ME = CTRL_POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (ctrl.pos == ME) begin
        entry <= ctrl.value;
      end else if (ctrl.pos < ME) begin
        entry <= left;
      end
    end else if (ctrl.del) begin
      if (ctrl.pos <= ME) begin
        entry <= right;
      end
    end
    if (ctrl.rd) begin
      hit <= (ctrl.pos == ME) ? entry : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ils_or_tree.sv @@
// Registered OR tree that gathers the one selected cell's entry.
// Depends on ils_pkg.
`default_nettype none

module ils_or_tree #(
  parameter int N = ils_pkg::CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic [ils_pkg::DATA_W-1:0] leaf [N],
  output logic      [ils_pkg::DATA_W-1:0] root
);
  import ils_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int WIDTH1 = level_nodes(N, 1);

  logic [DATA_W-1:0] node [LEVELS][WIDTH1];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int NIN  = level_nodes(N, l);
    localparam int NOUT = level_nodes(N, l + 1);
    for (genvar j = 0; j < WIDTH1; j++) begin : g_node
      if (j < NOUT) begin : g_or
        logic [DATA_W-1:0] acc;
        if (l == 0) begin : g_leaf
          always_comb begin
            acc = '0;
            for (int k = 0; k < TREE_RADIX; k++) begin
              if (j * TREE_RADIX + k < NIN) begin
                acc = acc | leaf[j * TREE_RADIX + k];
              end
            end
          end
        end else begin : g_inner
          always_comb begin
            acc = '0;
            for (int k = 0; k < TREE_RADIX; k++) begin
              if (j * TREE_RADIX + k < NIN) begin
                acc = acc | node[l-1][j * TREE_RADIX + k];
              end
            end
          end
        end
        always_ff @(posedge clk) begin
          node[l][j] <= acc;
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          node[l][j] <= '0;
        end
      end
    end
  end

  assign root = node[LEVELS-1][0];

endmodule

`default_nettype wire

@@ rtl/core/indexed_list_store.sv @@
// Indexed list store: ordered list of signed 32-bit entries in a chain of cells.
// A read passes the cells' hit registers, the registered OR tree that gathers it from the
// cells, and the output register before m_tvalid rises.
// A new operation is accepted only once the last has reached the output register; shifts happen on accept.
// Reset: rst (synchronous) empties the list and drops any operation in flight.
// Depends on ils_pkg, ils_cell and ils_or_tree.
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // op [2:0], position [11:3], value [43:12], zero [47:44]
  input  wire logic [ils_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // read_value [31:0], status [33:32], entry_count [42:34], zero [47:43]
  output logic      [ils_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ils_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMPW   = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int OUT_PAD = OUT_TDATA_W - DATA_W - STATUS_W - COUNT_OUT_W;

  logic                   accept;
  logic [OP_W-1:0]        op;
  logic [POS_W-1:0]       position;
  logic [DATA_W-1:0]      value;

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CMPW-1:0]        pos_cmp;
  logic [CMPW-1:0]        cnt_cmp;
  logic                   full;
  logic                   do_ins;
  logic                   do_del;
  logic                   do_rd;
  logic [CTRL_POS_W-1:0]  eff_pos;
  logic [STATUS_W-1:0]    status_next;
  ils_ctrl_t              ctrl;

  logic [DATA_W-1:0]      entry [CAPACITY];
  logic [DATA_W-1:0]      hit   [CAPACITY];
  logic [DATA_W-1:0]      root;

  logic [LEVELS:0]        pv;
  logic                   p_rd   [LEVELS+1];
  logic [STATUS_W-1:0]    p_st   [LEVELS+1];
  logic [COUNT_OUT_W-1:0] p_cnt  [LEVELS+1];
  logic                   out_load;

  assign op       = s_tdata[OP_W-1:0];
  assign position = s_tdata[OP_W +: POS_W];
  assign value    = s_tdata[OP_W + POS_W +: DATA_W];

  assign s_tready = ~(|pv);
  assign accept   = s_tvalid & s_tready;

  assign pos_cmp = CMPW'(position);
  assign cnt_cmp = CMPW'(count);
  assign full    = (count == CW'(CAPACITY));

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    do_rd       = 1'b0;
    eff_pos     = CTRL_POS_W'(position);
    status_next = ST_DONE;
    count_next  = count;
    unique case (op) inside
      OP_READ: begin
        if (pos_cmp < cnt_cmp) begin
          do_rd = 1'b1;
        end else begin
          status_next = ST_RANGE;
        end
      end
      OP_FRONT, OP_BACK, OP_AT: begin
        if (op == OP_FRONT) begin
          eff_pos = '0;
        end else if (op == OP_BACK) begin
          eff_pos = CTRL_POS_W'(count);
        end
        if (op == OP_AT && pos_cmp > cnt_cmp) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_cmp < cnt_cmp) begin
          do_del     = 1'b1;
          count_next = count - CW'(1);
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign ctrl.ins   = accept & do_ins;
  assign ctrl.del   = accept & do_del;
  assign ctrl.rd    = accept & do_rd;
  assign ctrl.pos   = eff_pos;
  assign ctrl.value = value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = entry[i+1];
    end
    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .entry (entry[i]),
      .hit   (hit[i])
    );
  end

  ils_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (hit),
    .root (root)
  );

  assign out_load = pv[LEVELS] & (~m_tvalid | m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pv       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      pv[0] <= accept;
      for (int k = 1; k < LEVELS; k++) begin
        pv[k] <= pv[k-1];
      end
      if (pv[LEVELS-1]) begin
        pv[LEVELS] <= 1'b1;
      end else if (out_load) begin
        pv[LEVELS] <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_rd[0]  <= do_rd;
      p_st[0]  <= status_next;
      p_cnt[0] <= COUNT_OUT_W'(count_next);
    end
    for (int k = 1; k <= LEVELS; k++) begin
      if (pv[k-1]) begin
        p_rd[k]  <= p_rd[k-1];
        p_st[k]  <= p_st[k-1];
        p_cnt[k] <= p_cnt[k-1];
      end
    end
    if (out_load) begin
      m_tdata <= {{OUT_PAD{1'b0}}, p_cnt[LEVELS], p_st[LEVELS],
                  (p_rd[LEVELS] ? root : {DATA_W{1'b1}})};
    end
  end

endmodule

`default_nettype wire
